// ===== rtl/tslf_pkg.sv =====
package tslf_pkg;

  // Input beat: one IR sample
  typedef struct packed {
    logic left_on_black;
    logic right_on_black;
    logic sample_valid;
  } in_item_t;

  // Output beat: one command result
  typedef struct packed {
    logic       send_frame;
    logic [5:0] left_speed;
    logic [5:0] right_speed;
    logic [8:0] wait_ticks;
    logic [2:0] route_phase;
    logic       last_of_run;
  } out_item_t;

  // One or two results produced by a single sample
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } res_pair_t;

  // Configuration registers
  typedef struct packed {
    logic       j1_right;
    logic       j2_right;
    logic [7:0] start_confirm;
    logic [7:0] side_confirm;
    logic [7:0] hard_turn;
    logic [7:0] hold_samples;
    logic [7:0] marker_confirm;
    logic [7:0] reacquire;
  } cfg_t;

  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgJ1Right       = 4'd0,
    CfgJ2Right       = 4'd1,
    CfgStartConfirm  = 4'd2,
    CfgSideConfirm   = 4'd3,
    CfgHardTurn      = 4'd4,
    CfgHoldSamples   = 4'd5,
    CfgMarkerConfirm = 4'd6,
    CfgReacquire     = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ModeWait     = 3'd0,
    ModeDelay    = 3'd1,
    ModeFollow   = 3'd2,
    ModeJunction = 3'd3,
    ModeStopped  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    SideNone  = 2'd0,
    SideLeft  = 2'd1,
    SideRight = 2'd2
  } side_e;

  // Route phases as reported on route_phase
  localparam logic [2:0] PhaseWait     = 3'd0;
  localparam logic [2:0] PhaseToJ1     = 3'd1;
  localparam logic [2:0] PhaseLoop     = 3'd2;
  localparam logic [2:0] PhaseToFinish = 3'd3;
  localparam logic [2:0] PhaseDone     = 3'd4;
  localparam logic [2:0] PhaseError    = 3'd5;

  // Speeds
  localparam logic [5:0] SpdStraightL  = 6'd30;
  localparam logic [5:0] SpdStraightR  = 6'd29;
  localparam logic [5:0] SpdLoopL      = 6'd27;
  localparam logic [5:0] SpdLoopR      = 6'd26;
  localparam logic [5:0] SpdFinishL    = 6'd22;
  localparam logic [5:0] SpdFinishR    = 6'd21;
  localparam logic [5:0] SpdSoftInner  = 6'd12;
  localparam logic [5:0] SpdSoftOuter  = 6'd32;
  localparam logic [5:0] SpdHardInner  = 6'd0;
  localparam logic [5:0] SpdHardOuter  = 6'd30;
  localparam logic [5:0] SpdCrawl      = 6'd17;
  localparam logic [5:0] SpdPivotJ1    = 6'd25;
  localparam logic [5:0] SpdPivotJ2    = 6'd24;
  localparam logic [5:0] SpdFineSlow   = 6'd8;
  localparam logic [5:0] SpdFineFast   = 6'd20;
  localparam logic [5:0] SpdCounterFst = 6'd18;
  localparam logic [5:0] SpdProbe      = 6'd13;
  localparam logic [5:0] SpdStop       = 6'd0;

  // Waits in ticks
  localparam logic [8:0] WaitNone    = 9'd0;
  localparam logic [8:0] WaitSample  = 9'd2;
  localparam logic [8:0] WaitStart   = 9'd300;
  localparam logic [8:0] WaitStop    = 9'd10;
  localparam logic [8:0] WaitFine    = 9'd5;
  localparam logic [8:0] WaitCounter = 9'd4;
  localparam logic [8:0] WaitProbe   = 9'd6;
  localparam logic [8:0] WaitReacq   = 9'd8;

  // Refresh and pivot timing
  localparam logic [3:0] RefreshPeriod = 4'd10;
  localparam logic [3:0] RefreshReacq  = 4'd12;
  localparam logic [3:0] RefreshMax    = 4'd15;
  localparam logic [3:0] PivotStart    = 4'd6;
  localparam logic [3:0] PivotLimit    = 4'd14;

  // Saturating 8-bit increment
  function automatic logic [7:0] sat_inc(input logic [7:0] x);
    return (x == 8'hFF) ? x : x + 8'd1;
  endfunction

  function automatic out_item_t mk_res(input logic send, input logic [5:0] l,
                                       input logic [5:0] r, input logic [8:0] w,
                                       input logic [2:0] ph, input logic last);
    out_item_t o;
    o.send_frame  = send;
    o.left_speed  = l;
    o.right_speed = r;
    o.wait_ticks  = w;
    o.route_phase = ph;
    o.last_of_run = last;
    return o;
  endfunction

endpackage

// ===== rtl/tslf_cfg.sv =====
module tslf_cfg import tslf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [CfgIdxW-1:0] idx_i,
  input  logic [7:0]         data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register file write decode; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CfgJ1Right:       cfg_d.j1_right       = data_i[0];
        CfgJ2Right:       cfg_d.j2_right       = data_i[0];
        CfgStartConfirm:  cfg_d.start_confirm  = data_i;
        CfgSideConfirm:   cfg_d.side_confirm   = data_i;
        CfgHardTurn:      cfg_d.hard_turn      = data_i;
        CfgHoldSamples:   cfg_d.hold_samples   = data_i;
        CfgMarkerConfirm: cfg_d.marker_confirm = data_i;
        CfgReacquire:     cfg_d.reacquire      = data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.j1_right       <= 1'b0;
      cfg_q.j2_right       <= 1'b1;
      cfg_q.start_confirm  <= 8'd10;
      cfg_q.side_confirm   <= 8'd2;
      cfg_q.hard_turn      <= 8'd6;
      cfg_q.hold_samples   <= 8'd3;
      cfg_q.marker_confirm <= 8'd5;
      cfg_q.reacquire      <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tslf_core.sv =====
module tslf_core import tslf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output res_pair_t res_o
);

  mode_e      mode_q, mode_d;
  side_e      side_q, side_d;
  logic [2:0] phase_q, phase_d;
  logic [7:0] start_q, start_d;
  logic [7:0] left_q, left_d;
  logic [7:0] right_q, right_d;
  logic [7:0] marker_q, marker_d;
  logic [7:0] hold_q, hold_d;
  logic [7:0] jbc_q, jbc_d;
  logic [7:0] jcc_q, jcc_d;
  logic [3:0] refresh_q, refresh_d;
  logic [3:0] pivot_q, pivot_d;

  // Sample decode
  logic lb, rb, sv, cen, lft, rgt, both;
  assign lb   = item_i.left_on_black;
  assign rb   = item_i.right_on_black;
  assign sv   = item_i.sample_valid;
  assign cen  = !lb && !rb;
  assign lft  = lb && !rb;
  assign rgt  = !lb && rb;
  assign both = lb && rb;

  // Counter increments and threshold checks
  logic [7:0] start_new, left_inc, right_inc, marker_inc, jbc_inc, jcc_inc;
  logic       start_ok, side_ok_l, side_ok_r, marker_ok, reacq_ok;
  assign start_new  = cen ? sat_inc(start_q) : 8'd0;
  assign left_inc   = sat_inc(left_q);
  assign right_inc  = sat_inc(right_q);
  assign marker_inc = sat_inc(marker_q);
  assign jbc_inc    = sat_inc(jbc_q);
  assign jcc_inc    = sat_inc(jcc_q);
  assign start_ok   = start_new >= cfg_i.start_confirm;
  assign side_ok_l  = left_inc >= cfg_i.side_confirm;
  assign side_ok_r  = right_inc >= cfg_i.side_confirm;
  assign marker_ok  = marker_inc >= cfg_i.marker_confirm;
  assign reacq_ok   = jcc_inc >= cfg_i.reacquire;

  // Correction strength: soft below the hard threshold
  logic       soft_side, soft_hold;
  logic [5:0] side_inner, side_outer, hold_inner, hold_outer;
  assign soft_side  = (lft ? left_inc : right_inc) < cfg_i.hard_turn;
  assign soft_hold  = 8'd1 < cfg_i.hard_turn;
  assign side_inner = soft_side ? SpdSoftInner : SpdHardInner;
  assign side_outer = soft_side ? SpdSoftOuter : SpdHardOuter;
  assign hold_inner = soft_hold ? SpdSoftInner : SpdHardInner;
  assign hold_outer = soft_hold ? SpdSoftOuter : SpdHardOuter;

  // Junction turn context
  logic       right_turn, expected;
  logic [5:0] pivot_spd;
  logic [4:0] pivot_sum;
  logic [3:0] pivot_next;
  assign right_turn = (phase_q == PhaseToJ1) ? cfg_i.j1_right : cfg_i.j2_right;
  assign pivot_spd  = (phase_q == PhaseToJ1) ? SpdPivotJ1 : SpdPivotJ2;
  assign expected   = right_turn ? rgt : lft;
  assign pivot_sum  = {1'b0, pivot_q} + 5'd2;
  always_comb begin
    pivot_next = pivot_q;
    if (jbc_inc[1:0] == 2'b00 && pivot_q < PivotLimit) begin
      pivot_next = (pivot_sum > {1'b0, PivotLimit}) ? PivotLimit : pivot_sum[3:0];
    end
  end

  // Refresh advance per follow sample, saturating
  logic [3:0] refresh_base;
  logic [4:0] refresh_sum;

  // Next state
  always_comb begin
    mode_d       = mode_q;
    side_d       = side_q;
    phase_d      = phase_q;
    start_d      = start_q;
    left_d       = left_q;
    right_d      = right_q;
    marker_d     = marker_q;
    hold_d       = hold_q;
    jbc_d        = jbc_q;
    jcc_d        = jcc_q;
    refresh_d    = refresh_q;
    pivot_d      = pivot_q;
    refresh_base = refresh_q;
    refresh_sum  = {1'b0, refresh_q} + 5'd2;
    case (mode_q)
      ModeWait: begin
        if (sv) begin
          start_d = start_new;
          if (start_ok) mode_d = ModeDelay;
        end
      end
      ModeDelay: begin
        if (sv && cen) begin
          phase_d = PhaseToJ1;
          mode_d  = ModeFollow;
        end else begin
          start_d = 8'd0;
          mode_d  = ModeWait;
        end
      end
      ModeFollow: begin
        if (!sv) begin
          phase_d = PhaseError;
          mode_d  = ModeStopped;
        end else if (cen) begin
          left_d   = 8'd0;
          right_d  = 8'd0;
          marker_d = 8'd0;
          if (hold_q != 8'd0) begin
            hold_d = hold_q - 8'd1;
          end else if (refresh_q >= RefreshPeriod) begin
            refresh_base = 4'd0;
          end
          refresh_sum = {1'b0, refresh_base} + 5'd2;
          refresh_d   = refresh_sum[4] ? RefreshMax : refresh_sum[3:0];
        end else if (lft || rgt) begin
          left_d   = lft ? left_inc : 8'd0;
          right_d  = rgt ? right_inc : 8'd0;
          marker_d = 8'd0;
          if ((lft && side_ok_l) || (rgt && side_ok_r)) begin
            side_d = lft ? SideLeft : SideRight;
            hold_d = cfg_i.hold_samples;
          end
          refresh_d = refresh_sum[4] ? RefreshMax : refresh_sum[3:0];
        end else begin
          left_d  = 8'd0;
          right_d = 8'd0;
          hold_d  = 8'd0;
          if (marker_ok) begin
            marker_d  = 8'd0;
            refresh_d = RefreshPeriod;
            if (phase_q == PhaseToJ1 || phase_q == PhaseLoop) begin
              mode_d  = ModeJunction;
              jbc_d   = 8'd0;
              jcc_d   = 8'd0;
              pivot_d = PivotStart;
            end else begin
              phase_d = PhaseDone;
              mode_d  = ModeStopped;
            end
          end else begin
            marker_d  = marker_inc;
            refresh_d = refresh_sum[4] ? RefreshMax : refresh_sum[3:0];
          end
        end
      end
      ModeJunction: begin
        if (!sv) begin
          left_d    = 8'd0;
          right_d   = 8'd0;
          marker_d  = 8'd0;
          hold_d    = 8'd0;
          refresh_d = RefreshReacq;
          phase_d   = PhaseError;
          mode_d    = ModeStopped;
        end else if (both) begin
          jcc_d   = 8'd0;
          jbc_d   = jbc_inc;
          pivot_d = pivot_next;
        end else if (cen) begin
          jbc_d = 8'd0;
          jcc_d = jcc_inc;
          if (reacq_ok) begin
            phase_d   = (phase_q == PhaseToJ1) ? PhaseLoop : PhaseToFinish;
            mode_d    = ModeFollow;
            left_d    = 8'd0;
            right_d   = 8'd0;
            marker_d  = 8'd0;
            hold_d    = 8'd0;
            refresh_d = RefreshReacq;
          end
        end else begin
          jbc_d = 8'd0;
          jcc_d = 8'd0;
        end
      end
      default: begin
        mode_d = ModeStopped;
      end
    endcase
  end

  // Result generation
  always_comb begin
    logic       send, two;
    logic [5:0] l, r;
    logic [8:0] w;
    send = 1'b0;
    two  = 1'b0;
    l    = SpdStop;
    r    = SpdStop;
    w    = WaitSample;
    case (mode_q)
      ModeWait: begin
        if (!sv) send = 1'b1;
        else if (start_ok) w = WaitStart;
      end
      ModeDelay: begin
        if (sv && cen) w = WaitNone;
      end
      ModeFollow: begin
        if (!sv) begin
          send = 1'b1;
          w    = WaitNone;
        end else if (cen) begin
          if (hold_q != 8'd0) begin
            if (side_q == SideLeft) begin
              send = 1'b1;
              l    = hold_inner;
              r    = hold_outer;
            end else if (side_q == SideRight) begin
              send = 1'b1;
              l    = hold_outer;
              r    = hold_inner;
            end
          end else if (refresh_q >= RefreshPeriod) begin
            send = 1'b1;
            if (phase_q == PhaseLoop) begin
              l = SpdLoopL;
              r = SpdLoopR;
            end else if (phase_q == PhaseToFinish) begin
              l = SpdFinishL;
              r = SpdFinishR;
            end else begin
              l = SpdStraightL;
              r = SpdStraightR;
            end
          end
        end else if (lft) begin
          if (side_ok_l) begin
            send = 1'b1;
            l    = side_inner;
            r    = side_outer;
          end
        end else if (rgt) begin
          if (side_ok_r) begin
            send = 1'b1;
            l    = side_outer;
            r    = side_inner;
          end
        end else begin
          send = 1'b1;
          l    = SpdCrawl;
          r    = SpdCrawl;
          if (marker_ok) begin
            w = WaitNone;
            // finish marker: crawl then stop
            if (!(phase_q == PhaseToJ1 || phase_q == PhaseLoop)) two = 1'b1;
          end
        end
      end
      ModeJunction: begin
        send = 1'b1;
        if (!sv) begin
          w = WaitSample;
        end else if (both) begin
          w = {5'd0, pivot_next};
          if (right_turn) l = pivot_spd;
          else r = pivot_spd;
        end else if (cen) begin
          l = SpdProbe;
          r = SpdProbe;
          w = reacq_ok ? WaitReacq : WaitProbe;
        end else if (expected) begin
          w = WaitFine;
          l = right_turn ? SpdFineFast : SpdFineSlow;
          r = right_turn ? SpdFineSlow : SpdFineFast;
        end else begin
          w = WaitCounter;
          l = right_turn ? SpdFineSlow : SpdCounterFst;
          r = right_turn ? SpdCounterFst : SpdFineSlow;
        end
      end
      default: begin
        send = 1'b1;
        w    = WaitStop;
      end
    endcase
    res_o.two    = two;
    res_o.first  = mk_res(send, l, r, two ? WaitNone : w, phase_d, !two);
    res_o.second = mk_res(1'b1, SpdStop, SpdStop, WaitSample, phase_d, 1'b1);
  end

  // State registers, updated once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeWait;
      side_q    <= SideNone;
      phase_q   <= PhaseWait;
      start_q   <= 8'd0;
      left_q    <= 8'd0;
      right_q   <= 8'd0;
      marker_q  <= 8'd0;
      hold_q    <= 8'd0;
      jbc_q     <= 8'd0;
      jcc_q     <= 8'd0;
      refresh_q <= RefreshPeriod;
      pivot_q   <= PivotStart;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      side_q    <= side_d;
      phase_q   <= phase_d;
      start_q   <= start_d;
      left_q    <= left_d;
      right_q   <= right_d;
      marker_q  <= marker_d;
      hold_q    <= hold_d;
      jbc_q     <= jbc_d;
      jcc_q     <= jcc_d;
      refresh_q <= refresh_d;
      pivot_q   <= pivot_d;
    end
  end

endmodule

// ===== rtl/tslf_outq.sv =====
module tslf_outq import tslf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_pair_t res_i,
  output logic      can_push_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [1:0] cnt_q, cnt_d;
  out_item_t  head_q, head_d;
  out_item_t  tail_q, tail_d;
  logic       pop;

  assign pop        = (cnt_q != 2'd0) && !out_stall_i;
  // Take a new sample only when the buffer is empty or drains this cycle
  assign can_push_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (push_i) begin
      head_d = res_i.first;
      tail_d = res_i.second;
      cnt_d  = res_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = head_q;

endmodule

// ===== rtl/two_sensor_line_follow_route_sequencer.sv =====
// Channel   Direction  Handshake                 Beat
// in        input      in_valid_i / in_stall_o   in_item_t: one IR sample
// out       output     out_valid_o / out_stall_i out_item_t: one command result
// cfg       input      cfg_valid_i / cfg_ready_o register index + 8-bit data
//
// A sample is decoded and the route state updated in the cycle it is accepted;
// its results sit in a two-entry result register the next cycle.
// Samples giving one result flow at one per cycle while the output is not stalled;
// the finish marker sample gives two results, which leave in turn through the single output port.
// Reset restores the register defaults and the wait-for-start state.
// in_stall_o rises while results are pending that will not drain this cycle.
module two_sensor_line_follow_route_sequencer import tslf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  cfg_t      cfg;
  res_pair_t res;
  logic      can_push, in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !can_push;
  assign in_fire     = in_valid_i && can_push;

  tslf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i && cfg_ready_o),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  tslf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  tslf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .res_i       (res),
    .can_push_o  (can_push),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/tslf_chk.sv =====
module tslf_chk import tslf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result beat changed");

  // No frame means zero speeds
  a_nosend_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.send_frame |->
      out_data_i.left_speed == 6'd0 && out_data_i.right_speed == 6'd0)
    else $error("speeds set without a frame");

  // Wait is only given on the last result of a sample
  a_wait_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.last_of_run |-> out_data_i.wait_ticks == 9'd0)
    else $error("wait on a non-final result");

  // Only the finish marker yields more than one result
  a_multi_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.last_of_run |-> out_data_i.route_phase == PhaseDone)
    else $error("multi-result sample outside finish");

  // Second result follows right after the first is taken
  a_second_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !out_data_i.last_of_run |=>
      out_valid_i && out_data_i.last_of_run)
    else $error("second result missing");

endmodule

bind two_sensor_line_follow_route_sequencer tslf_chk u_tslf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// ===== tb/sv/two_sensor_line_follow_route_sequencer_test.sv =====
module two_sensor_line_follow_route_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tslf_pkg::*;

  // Sensor patterns as {left, right, read ok}
  localparam in_item_t Centered    = 3'b001;
  localparam in_item_t LeftOnLine  = 3'b101;
  localparam in_item_t RightOnLine = 3'b011;
  localparam in_item_t BothOnLine  = 3'b111;
  localparam in_item_t NoReadClear = 3'b000;
  localparam in_item_t NoReadBoth  = 3'b110;

  // Index past the register file: a write there must change nothing
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'd9;

  localparam int HoldOffCycles = 64;

  // Tracks the car's route state and the command beats it must produce
  class route_tracker;
    logic       j1_right, j2_right;
    logic [7:0] start_need, side_need, hard_from, hold_len, marker_need, reacq_need;

    mode_e      mode;
    side_e      last_side;
    logic [2:0] phase;
    logic [7:0] start_cnt, left_cnt, right_cnt, marker_cnt, hold_cnt;
    logic [7:0] jblack_cnt, jcenter_cnt;
    logic [3:0] refresh, pivot;

    out_item_t  step_cmds[$];
    out_item_t  pending[$];
    int         errors;

    function new();
      j1_right    = 1'b0;
      j2_right    = 1'b1;
      start_need  = 8'd10;
      side_need   = 8'd2;
      hard_from   = 8'd6;
      hold_len    = 8'd3;
      marker_need = 8'd5;
      reacq_need  = 8'd4;
      mode        = ModeWait;
      last_side   = SideNone;
      phase       = PhaseWait;
      start_cnt   = '0;
      left_cnt    = '0;
      right_cnt   = '0;
      marker_cnt  = '0;
      hold_cnt    = '0;
      jblack_cnt  = '0;
      jcenter_cnt = '0;
      refresh     = 4'd10;
      pivot       = 4'd6;
      errors      = 0;
    endfunction

    function logic [7:0] bump(logic [7:0] x);
      return (x == 8'hFF) ? x : x + 8'd1;
    endfunction

    function void apply_setting(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      case (idx)
        CfgJ1Right:       j1_right    = val[0];
        CfgJ2Right:       j2_right    = val[0];
        CfgStartConfirm:  start_need  = val;
        CfgSideConfirm:   side_need   = val;
        CfgHardTurn:      hard_from   = val;
        CfgHoldSamples:   hold_len    = val;
        CfgMarkerConfirm: marker_need = val;
        CfgReacquire:     reacq_need  = val;
        default: ;
      endcase
    endfunction

    function void emit(logic send, logic [5:0] l, logic [5:0] r, logic [8:0] w);
      out_item_t c;
      c             = '0;
      c.send_frame  = send;
      c.left_speed  = l;
      c.right_speed = r;
      c.wait_ticks  = w;
      step_cmds.push_back(c);
    endfunction

    function void clear_counts();
      left_cnt   = '0;
      right_cnt  = '0;
      marker_cnt = '0;
      hold_cnt   = '0;
    endfunction

    // Soft correction below the hard threshold, hard from it on
    function void steer(side_e side, logic [7:0] count);
      logic [5:0] inner, outer;
      inner = (count < hard_from) ? 6'd12 : 6'd0;
      outer = (count < hard_from) ? 6'd32 : 6'd30;
      if (side == SideLeft) emit(1'b1, inner, outer, 9'd2);
      else emit(1'b1, outer, inner, 9'd2);
    endfunction

    function void follow(logic lb, logic rb, logic ok);
      if (!ok) begin
        phase = PhaseError;
        mode  = ModeStopped;
        emit(1'b1, 6'd0, 6'd0, 9'd0);
        return;
      end
      case ({lb, rb})
        2'b00: begin
          left_cnt   = '0;
          right_cnt  = '0;
          marker_cnt = '0;
          if (hold_cnt != 0) begin
            hold_cnt--;
            if (last_side == SideLeft || last_side == SideRight) steer(last_side, 8'd1);
            else emit(1'b0, 6'd0, 6'd0, 9'd2);
          end else if (refresh >= 4'd10) begin
            // straight speed depends on the leg of the route
            case (phase)
              PhaseLoop:     emit(1'b1, 6'd27, 6'd26, 9'd2);
              PhaseToFinish: emit(1'b1, 6'd22, 6'd21, 9'd2);
              default:       emit(1'b1, 6'd30, 6'd29, 9'd2);
            endcase
            refresh = '0;
          end else begin
            emit(1'b0, 6'd0, 6'd0, 9'd2);
          end
        end
        2'b10: begin
          left_cnt   = bump(left_cnt);
          right_cnt  = '0;
          marker_cnt = '0;
          if (left_cnt >= side_need) begin
            last_side = SideLeft;
            hold_cnt  = hold_len;
            steer(SideLeft, left_cnt);
          end else begin
            emit(1'b0, 6'd0, 6'd0, 9'd2);
          end
        end
        2'b01: begin
          right_cnt  = bump(right_cnt);
          left_cnt   = '0;
          marker_cnt = '0;
          if (right_cnt >= side_need) begin
            last_side = SideRight;
            hold_cnt  = hold_len;
            steer(SideRight, right_cnt);
          end else begin
            emit(1'b0, 6'd0, 6'd0, 9'd2);
          end
        end
        default: begin
          left_cnt   = '0;
          right_cnt  = '0;
          hold_cnt   = '0;
          marker_cnt = bump(marker_cnt);
          if (marker_cnt >= marker_need) begin
            clear_counts();
            refresh = 4'd10;
            emit(1'b1, 6'd17, 6'd17, 9'd0);
            if (phase == PhaseToJ1 || phase == PhaseLoop) begin
              mode        = ModeJunction;
              jblack_cnt  = '0;
              jcenter_cnt = '0;
              pivot       = 4'd6;
            end else begin
              // finish marker: crawl, then stop
              phase = PhaseDone;
              mode  = ModeStopped;
              emit(1'b1, 6'd0, 6'd0, 9'd2);
            end
            return;
          end
          emit(1'b1, 6'd17, 6'd17, 9'd2);
        end
      endcase
      refresh = (refresh > 4'd13) ? 4'd15 : refresh + 4'd2;
    endfunction

    function void junction(logic lb, logic rb, logic ok);
      logic       right_turn;
      logic [5:0] pivot_spd;
      right_turn = (phase == PhaseToJ1) ? j1_right : j2_right;
      pivot_spd  = (phase == PhaseToJ1) ? 6'd25 : 6'd24;
      if (!ok) begin
        clear_counts();
        refresh = 4'd12;
        phase   = PhaseError;
        mode    = ModeStopped;
        emit(1'b1, 6'd0, 6'd0, 9'd2);
        return;
      end
      case ({lb, rb})
        2'b11: begin
          // pivot in place, longer on every fourth black sample in a row
          jcenter_cnt = '0;
          jblack_cnt  = bump(jblack_cnt);
          if (jblack_cnt[1:0] == 2'b00 && pivot < 4'd14)
            pivot = (pivot > 4'd12) ? 4'd14 : pivot + 4'd2;
          if (right_turn) emit(1'b1, pivot_spd, 6'd0, {5'd0, pivot});
          else emit(1'b1, 6'd0, pivot_spd, {5'd0, pivot});
        end
        2'b00: begin
          jblack_cnt  = '0;
          jcenter_cnt = bump(jcenter_cnt);
          if (jcenter_cnt >= reacq_need) begin
            phase   = (phase == PhaseToJ1) ? PhaseLoop : PhaseToFinish;
            mode    = ModeFollow;
            clear_counts();
            refresh = 4'd12;
            emit(1'b1, 6'd13, 6'd13, 9'd8);
          end else begin
            emit(1'b1, 6'd13, 6'd13, 9'd6);
          end
        end
        default: begin
          jblack_cnt  = '0;
          jcenter_cnt = '0;
          // line seen on the side the turn swings to: fine turn, else counter-steer
          if (right_turn ? rb : lb) begin
            if (right_turn) emit(1'b1, 6'd20, 6'd8, 9'd5);
            else emit(1'b1, 6'd8, 6'd20, 9'd5);
          end else begin
            if (right_turn) emit(1'b1, 6'd8, 6'd18, 9'd4);
            else emit(1'b1, 6'd18, 6'd8, 9'd4);
          end
        end
      endcase
    endfunction

    // Accepted sample beat: advance the route and queue its commands
    function void note_sample(in_item_t s);
      step_cmds.delete();
      case (mode)
        ModeWait: begin
          if (!s.sample_valid) begin
            emit(1'b1, 6'd0, 6'd0, 9'd2);
          end else begin
            start_cnt = (!s.left_on_black && !s.right_on_black) ? bump(start_cnt) : 8'd0;
            if (start_cnt >= start_need) begin
              mode = ModeDelay;
              emit(1'b0, 6'd0, 6'd0, 9'd300);
            end else begin
              emit(1'b0, 6'd0, 6'd0, 9'd2);
            end
          end
        end
        ModeDelay: begin
          if (s.sample_valid && !s.left_on_black && !s.right_on_black) begin
            phase = PhaseToJ1;
            mode  = ModeFollow;
            emit(1'b0, 6'd0, 6'd0, 9'd0);
          end else begin
            start_cnt = '0;
            mode      = ModeWait;
            emit(1'b0, 6'd0, 6'd0, 9'd2);
          end
        end
        ModeFollow:   follow(s.left_on_black, s.right_on_black, s.sample_valid);
        ModeJunction: junction(s.left_on_black, s.right_on_black, s.sample_valid);
        default:      emit(1'b1, 6'd0, 6'd0, 9'd10);
      endcase
      // every beat carries the final phase; only the last carries the wait
      foreach (step_cmds[k]) begin
        step_cmds[k].route_phase = phase;
        step_cmds[k].last_of_run = (k == step_cmds.size() - 1);
        if (k != step_cmds.size() - 1) step_cmds[k].wait_ticks = '0;
        pending.push_back(step_cmds[k]);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_field(string name, logic [8:0] got, logic [8:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_command(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("command beat %h with none expected", got));
        return;
      end
      want = pending.pop_front();
      check_field("send_frame", 9'(got.send_frame), 9'(want.send_frame));
      check_field("left_speed", 9'(got.left_speed), 9'(want.left_speed));
      check_field("right_speed", 9'(got.right_speed), 9'(want.right_speed));
      check_field("wait_ticks", got.wait_ticks, want.wait_ticks);
      check_field("route_phase", 9'(got.route_phase), 9'(want.route_phase));
      check_field("last_of_run", 9'(got.last_of_run), 9'(want.last_of_run));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [7:0]           cfg_data_i  = '0;

  route_tracker tracker = new();

  int       burst_left;
  int       run_left;
  in_item_t run_pat;
  int       hold_off_req;
  int       holds_done;

  // Opening drive, set up with j1 right, start 2, side 1, hard 3, hold 2, marker 2, reacq 2
  in_item_t opening [28] = '{
    // waiting: failed reads, off-center samples, start count and its loss in the delay
    NoReadClear, NoReadBoth, BothOnLine, Centered, LeftOnLine, Centered, Centered,
    RightOnLine, Centered, Centered, NoReadClear, Centered, Centered, Centered,
    // following: refresh, soft then hard left, hold, right, marker into junction 1
    Centered, LeftOnLine, LeftOnLine, LeftOnLine, Centered, Centered, Centered,
    RightOnLine, BothOnLine, BothOnLine,
    // junction 1 turning right: pivot, fine turn, counter-steer, probe
    BothOnLine, RightOnLine, LeftOnLine, Centered
  };

  two_sensor_line_follow_route_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sample beats go out in bursts with random gaps between them
  task automatic offer_sample(input in_item_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_sample(s);
  endtask

  task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.apply_setting(idx, val);
  endtask

  task automatic apply_settings(input logic j1, input logic j2, input logic [7:0] start,
                                input logic [7:0] side, input logic [7:0] hard,
                                input logic [7:0] hold, input logic [7:0] marker,
                                input logic [7:0] reacq);
    write_setting(CfgJ1Right, {7'd0, j1});
    write_setting(CfgJ2Right, {7'd0, j2});
    write_setting(CfgStartConfirm, start);
    write_setting(CfgSideConfirm, side);
    write_setting(CfgHardTurn, hard);
    write_setting(CfgHoldSamples, hold);
    write_setting(CfgMarkerConfirm, marker);
    write_setting(CfgReacquire, reacq);
    write_setting(CfgIdxSpare, 8'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_count();
    return 8'($urandom_range(0, 7));
  endfunction

  task automatic apply_random_settings();
    apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_count(),
                   rand_count(), rand_count(), rand_count(), rand_count(), rand_count());
  endtask

  // Stop offering and let every expected command drain
  task automatic go_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Runs of one sensor pattern, chosen to suit where the car is on the route.
  // Read failures only while waiting or stopped; the finish marker is never confirmed here.
  function automatic in_item_t route_sample(bit allow_marker);
    in_item_t s;
    int       pick;
    if (run_left == 0) begin
      pick     = $urandom_range(0, 99);
      run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      case (tracker.mode)
        ModeWait, ModeDelay: run_pat = (pick < 75) ? Centered : in_item_t'($urandom_range(0, 7));
        ModeFollow: run_pat = (pick < 35) ? Centered : (pick < 55) ? LeftOnLine :
                              (pick < 75) ? RightOnLine : BothOnLine;
        ModeJunction: run_pat = (pick < 30) ? BothOnLine : (pick < 60) ? Centered :
                                (pick < 80) ? LeftOnLine : RightOnLine;
        default: run_pat = in_item_t'($urandom_range(0, 7));
      endcase
    end
    run_left--;
    s = run_pat;
    if (tracker.mode == ModeFollow || tracker.mode == ModeJunction) begin
      s.sample_valid = 1'b1;
      if (tracker.mode == ModeFollow && s.left_on_black && s.right_on_black &&
          (!allow_marker || tracker.phase == PhaseToFinish) &&
          tracker.bump(tracker.marker_cnt) >= tracker.marker_need) begin
        s        = Centered;
        run_left = 0;
      end
    end
    return s;
  endfunction

  task automatic random_run(input int n, input bit allow_marker);
    repeat (n) offer_sample(route_sample(allow_marker));
  endtask

  // Receiver stall pattern: free, light and heavy stretches, plus requested hold-offs
  initial begin
    int stretch;
    int pct;
    forever begin
      if (hold_off_req != holds_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        stretch = $urandom_range(4, 40);
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 30;
          default: pct = 75;
        endcase
        for (int c = 0; c < stretch && hold_off_req == holds_done; c++) begin
          out_stall_i <= ($urandom_range(0, 99) < pct);
          @(posedge clk_i);
        end
      end
    end
  end

  // Command beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_command(out_data_o);
  end

  initial begin
    #2ms;
    $display("two_sensor_line_follow_route_sequencer_test: done, errors");
    $finish;
  end

  initial begin
    burst_left   = 0;
    run_left     = 0;
    run_pat      = Centered;
    hold_off_req = 0;
    holds_done   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk from the start line into junction 1
    apply_settings(1'b1, 1'b0, 8'd2, 8'd1, 8'd3, 8'd2, 8'd2, 8'd2);
    foreach (opening[k]) offer_sample(opening[k]);
    go_idle();

    // all counts zero: every threshold met at once, no hold
    apply_settings(1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    random_run(16, 1'b0);
    go_idle();

    // all counts at the top: no correction, no marker
    apply_settings(1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    random_run(16, 1'b1);
    go_idle();

    // random route run under a long receiver hold-off
    apply_random_settings();
    hold_off_req <= hold_off_req + 1;
    random_run(16, 1'b1);
    go_idle();

    apply_random_settings();
    random_run(16, 1'b0);

    // end of the route: finish marker, or a failed read wherever the car is
    if ($urandom_range(0, 1) == 1) begin
      while (tracker.mode != ModeStopped)
        offer_sample((tracker.mode == ModeFollow) ? BothOnLine : Centered);
    end else begin
      offer_sample(in_item_t'({2'($urandom_range(0, 3)), 1'b0}));
    end

    // stopped car ignores whatever comes next
    repeat (6) offer_sample(in_item_t'($urandom_range(0, 7)));

    in_valid_i <= 1'b0;
    for (int c = 0; c < 4000 && tracker.pending.size() != 0; c++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d command beats never arrived", tracker.pending.size()));

    if (tracker.errors == 0) begin
      $display("two_sensor_line_follow_route_sequencer_test: done, clean");
    end else begin
      $display("two_sensor_line_follow_route_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tslf_pkg.sv
rtl/tslf_cfg.sv
rtl/tslf_core.sv
rtl/tslf_outq.sv
rtl/two_sensor_line_follow_route_sequencer.sv
rtl/tslf_chk.sv
tb/sv/two_sensor_line_follow_route_sequencer_test.sv
